// File: hdl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// shared types and constants of the streaming utf-8 validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8sv_pkg;

  localparam int unsigned LimitWidth = 27;
  localparam logic [LimitWidth-1:0] LimitReset = 27'h400_0000;

  localparam logic [7:0] AsciiTop   = 8'h7f;
  localparam logic [7:0] Lead2Lo    = 8'hc2;
  localparam logic [7:0] Lead2Hi    = 8'hdf;
  localparam logic [7:0] Lead3Lo    = 8'he0;
  localparam logic [7:0] Lead3Hi    = 8'hef;
  localparam logic [7:0] Lead4Lo    = 8'hf0;
  localparam logic [7:0] Lead4Hi    = 8'hf4;
  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContTag    = 8'h80;

  localparam logic [20:0] ScalarMax = 21'h10ffff;
  localparam logic [20:0] SurrLo    = 21'h00d800;
  localparam logic [20:0] SurrHi    = 21'h00dfff;
  localparam logic [20:0] Min2      = 21'h000080;
  localparam logic [20:0] Min3      = 21'h000800;
  localparam logic [20:0] Min4      = 21'h010000;

  typedef enum logic [1:0] {
    MODE_DATA        = 2'd0,
    MODE_FIN_NATURAL = 2'd1,
    MODE_FIN_OTHER   = 2'd2,
    MODE_FIN_ALT     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_BAD_CONT   = 3'd2,
    ST_BAD_SCALAR = 3'd3,
    ST_LIMIT      = 3'd4,
    ST_MID_SEQ    = 3'd5,
    ST_TERMINAL   = 3'd6
  } status_t;

  // stream state that reset clears
  typedef struct packed {
    logic [1:0]            held_count;
    logic [2:0]            seq_len;
    logic [20:0]           partial;
    logic [LimitWidth-1:0] received;
    logic                  stopped;
  } state_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [2:0]  released_count;
    logic [31:0] released_bytes;
    logic [20:0] code_point;
    logic        finished;
  } result_t;

  // write into the held byte store
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
    logic [7:0] data;
  } held_wr_t;

endpackage

// File: hdl/u8sv_if.sv
// ----------------------------------------------------------------------------
// u8sv channel interfaces
// valid/ready channels for bytes in, results out and the limit register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8sv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface u8sv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  released_count;
  logic [31:0] released_bytes;
  logic [20:0] code_point;
  logic        finished;

  modport source (
    output valid, output status, output released_count, output released_bytes,
    output code_point, output finished, input ready
  );
  modport sink (
    input valid, input status, input released_count, input released_bytes,
    input code_point, input finished, output ready
  );
endinterface

interface u8sv_cfg_if;
  logic        valid;
  logic        ready;
  logic [26:0] byte_limit;

  modport source (output valid, output byte_limit, input ready);
  modport sink (input valid, input byte_limit, output ready);
endinterface

// File: hdl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while results are taken, set by the combinational decode step
// the result register frees up in the same cycle the result is taken
// reset: synchronous, clears the stream state and output valid, reloads the byte limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_validator
  import u8sv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  u8sv_in_if.sink    byte_in,
  u8sv_out_if.source result_out,
  u8sv_cfg_if.sink   cfg
);

  // stream state, held bytes of the open sequence and the limit register
  state_t                state;
  state_t                state_next;
  logic [2:0][7:0]       held;
  logic [LimitWidth-1:0] byte_limit;

  // result register
  result_t res;
  result_t res_next;
  logic    res_valid;

  held_wr_t held_wr;
  logic     accept;

  // the result register can take a new result whenever it is empty or drains
  assign byte_in.ready = !res_valid || result_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  // limit writes are always taken
  assign cfg.ready = 1'b1;

  u8sv_step u_step (
    .mode       (byte_in.mode),
    .data_byte  (byte_in.data_byte),
    .byte_limit (byte_limit),
    .st         (state),
    .held       (held),
    .st_next    (state_next),
    .held_wr    (held_wr),
    .res        (res_next)
  );

  // control state and the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      res_valid  <= 1'b0;
      byte_limit <= LimitReset;
    end else begin
      if (accept) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        byte_limit <= cfg.byte_limit;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
      if (held_wr.we) begin
        held[held_wr.idx] <= held_wr.data;
      end
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.status         = res.status;
  assign result_out.released_count = res.released_count;
  assign result_out.released_bytes = res.released_bytes;
  assign result_out.code_point     = res.code_point;
  assign result_out.finished       = res.finished;

  // a request on a stopped stream always answers terminal
  a_terminal: assert property (@(posedge clk) disable iff (rst)
    accept && state.stopped |=> result_out.status == ST_TERMINAL)
    else $error("stopped stream did not answer terminal");

  // an open sequence never holds as many bytes as its length
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    state.held_count != 2'd0 |-> ({1'b0, state.held_count} < state.seq_len))
    else $error("held count out of range for sequence length");

  // released bytes only come with an ok status
  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.released_count != 3'd0 |-> res.status == ST_OK)
    else $error("bytes released with an error status");

  // a finish leaves the stream stopped
  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.finished |-> state.stopped)
    else $error("finish did not stop the stream");

endmodule

// File: hdl/u8sv_step.sv
// ----------------------------------------------------------------------------
// u8sv_step
// one-byte decode step: next stream state, held byte write and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sv_step
  import u8sv_pkg::*;
(
  input  logic [1:0]            mode,
  input  logic [7:0]            data_byte,
  input  logic [LimitWidth-1:0] byte_limit,
  input  state_t                st,
  input  logic [2:0][7:0]       held,
  output state_t                st_next,
  output held_wr_t              held_wr,
  output result_t               res
);

  logic [20:0] shifted;
  logic [20:0] minimum;
  logic        bad_scalar;
  logic [31:0] packed_bytes;

  // continuation byte folded into the scalar
  assign shifted = {st.partial[14:0], data_byte[5:0]};

  always_comb begin
    case (st.seq_len)
      3'd2:    minimum = Min2;
      3'd3:    minimum = Min3;
      default: minimum = Min4;
    endcase
  end

  assign bad_scalar = (shifted < minimum) || (shifted > ScalarMax) ||
                      ((shifted >= SurrLo) && (shifted <= SurrHi));

  always_comb begin
    case (st.held_count)
      2'd1:    packed_bytes = {16'h0000, data_byte, held[0]};
      2'd2:    packed_bytes = {8'h00, data_byte, held[1], held[0]};
      default: packed_bytes = {data_byte, held[2], held[1], held[0]};
    endcase
  end

  always_comb begin
    st_next = st;
    held_wr = '{we: 1'b0, idx: st.held_count, data: data_byte};
    res     = '{status: ST_OK, released_count: 3'd0, released_bytes: 32'h0,
                code_point: 21'h0, finished: 1'b0};

    if (st.stopped) begin
      res.status = ST_TERMINAL;
    end else if (mode != MODE_DATA) begin
      st_next.stopped = 1'b1;
      if ((mode == MODE_FIN_NATURAL) && (st.held_count != 2'd0)) begin
        res.status = ST_MID_SEQ;
      end else begin
        res.finished = 1'b1;
      end
    end else if (st.received >= byte_limit) begin
      res.status      = ST_LIMIT;
      st_next.stopped = 1'b1;
    end else begin
      st_next.received = st.received + LimitWidth'(1);
      if (st.held_count == 2'd0) begin
        if (data_byte <= AsciiTop) begin
          res.released_count = 3'd1;
          res.released_bytes = {24'h000000, data_byte};
          res.code_point     = {13'h0000, data_byte};
        end else if (data_byte >= Lead2Lo && data_byte <= Lead2Hi) begin
          st_next.seq_len    = 3'd2;
          st_next.partial    = {16'h0000, data_byte[4:0]};
          st_next.held_count = 2'd1;
          held_wr.we         = 1'b1;
        end else if (data_byte >= Lead3Lo && data_byte <= Lead3Hi) begin
          st_next.seq_len    = 3'd3;
          st_next.partial    = {17'h00000, data_byte[3:0]};
          st_next.held_count = 2'd1;
          held_wr.we         = 1'b1;
        end else if (data_byte >= Lead4Lo && data_byte <= Lead4Hi) begin
          st_next.seq_len    = 3'd4;
          st_next.partial    = {18'h00000, data_byte[2:0]};
          st_next.held_count = 2'd1;
          held_wr.we         = 1'b1;
        end else begin
          res.status      = ST_BAD_LEAD;
          st_next.stopped = 1'b1;
        end
      end else if ((data_byte & ContMask) != ContTag) begin
        res.status      = ST_BAD_CONT;
        st_next.stopped = 1'b1;
      end else if (({1'b0, st.held_count} + 3'd1) < st.seq_len) begin
        st_next.partial    = shifted;
        st_next.held_count = st.held_count + 2'd1;
        held_wr.we         = 1'b1;
      end else if (bad_scalar) begin
        res.status      = ST_BAD_SCALAR;
        st_next.stopped = 1'b1;
      end else begin
        res.released_count = {1'b0, st.held_count} + 3'd1;
        res.released_bytes = packed_bytes;
        res.code_point     = shifted;
        st_next.held_count = 2'd0;
        st_next.seq_len    = 3'd0;
        st_next.partial    = 21'h0;
      end
    end
  end

endmodule
